// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the ordered list block.
// Depends on nothing; each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a consequence holds in the same cycle as its trigger.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequence holds in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/olar_pkg.sv =====
// Types and constants for the ordered list block: beat structs, codes, and the
// command and status groups between controller and datapath. Depends on nothing.
package olar_pkg;

  localparam int CAPACITY = 16;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 7;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int IDX_W    = 8;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_NEXT,
    RD_SKIP
  } rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_PRIME,
    S_SHIFT,
    S_DUMP_PRIME,
    S_DUMP,
    S_REPLY
  } state_t;

  typedef struct packed {
    op_t                     operation;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } in_beat_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] element;
    logic [POS_W-1:0]        position;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } out_beat_t;

  typedef struct packed {
    logic    capture;
    logic    append;
    logic    cnt_dec;
    logic    ptr_idx;
    logic    ptr_zero;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    shift_wr;
    logic    dump_load;
    logic    reply_load;
    logic    set_stat;
    status_t stat;
  } cmd_t;

  typedef struct packed {
    op_t              op;
    logic             is_empty;
    logic             is_full;
    logic             idx_bad;
    logic             shift_none;
    logic             shift_done;
    logic             dump_last;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage

// ===== hdl/ordered_list_append_remove.sv =====
// Ordered list of signed 32-bit values, front at position zero, holding up to CAPACITY
// (16) entries in a memory with one write port and one read port. Append and unknown
// operations go from accept through decode to the reply; remove at index i of a list
// of n first moves the later elements up one place, one element per cycle, when there
// are any; dump gives one memory read per beat. The next request is accepted once the
// previous one has loaded its final beat into the output register.
// Depends on olar_pkg, olar_ctrl, olar_datapath and assert_macros.svh.
`include "assert_macros.svh"

module ordered_list_append_remove (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  olar_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output olar_pkg::out_beat_t out_data
);
  import olar_pkg::*;

  cmd_t cmd;
  sts_t sts;

  olar_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  olar_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

  `ASSERT_ALWAYS(a_count_bound, sts.count <= CNT_W'(CAPACITY), "count above capacity")
  `ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
  `ASSERT_SAME(a_mid_ok, out_valid && !out_data.last, out_data.status == ST_OK, "bad mid beat")

endmodule

// ===== hdl/olar_datapath.sv =====
// Datapath of the ordered list: element memory, count, position pointer,
// captured request and the output register. Depends on olar_pkg.
module olar_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  olar_pkg::in_beat_t  in_data,
  input  olar_pkg::cmd_t      cmd,
  input  logic                out_ready,
  output olar_pkg::sts_t      sts,
  output olar_pkg::out_beat_t out_data,
  output logic                out_valid
);
  import olar_pkg::*;

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_data_r;

  in_beat_t         in_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  status_t          stat_r, stat_nxt;
  out_beat_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0] rd_ptr;
  logic [AW-1:0]    rd_addr;
  logic [IDX_W:0]   idx_p1;
  logic             out_free;
  logic             dump_last;

  always_comb begin
    case (cmd.rd_sel)
      RD_PTR:  rd_ptr = ptr_r;
      RD_NEXT: rd_ptr = ptr_r + CNT_W'(1);
      RD_SKIP: rd_ptr = ptr_r + CNT_W'(2);
      default: rd_ptr = ptr_r;
    endcase
    rd_addr = rd_ptr[AW-1:0];
  end

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[count_r[AW-1:0]] <= in_r.value;
    end else if (cmd.shift_wr) begin
      mem[ptr_r[AW-1:0]] <= rd_data_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign dump_last = (ptr_r + CNT_W'(1)) == count_r;
  assign idx_p1    = {1'b0, in_r.index} + (IDX_W+1)'(1);

  always_comb begin
    sts.op         = in_r.operation;
    sts.is_empty   = (count_r == '0);
    sts.is_full    = (count_r >= CNT_W'(CAPACITY));
    sts.idx_bad    = ({1'b0, in_r.index} >= (IDX_W+1)'(count_r));
    sts.shift_none = (idx_p1 >= (IDX_W+1)'(count_r));
    sts.shift_done = ((ptr_r + CNT_W'(2)) >= count_r);
    sts.dump_last  = dump_last;
    sts.out_free   = out_free;
    sts.count      = count_r;
  end

  always_comb begin
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    stat_nxt      = stat_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (cmd.append) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end

    if (cmd.ptr_idx) begin
      ptr_nxt = in_r.index[CNT_W-1:0];
    end else if (cmd.ptr_zero) begin
      ptr_nxt = '0;
    end else if (cmd.shift_wr || cmd.dump_load) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end

    if (cmd.set_stat) begin
      stat_nxt = cmd.stat;
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.dump_load) begin
      out_nxt.status   = ST_OK;
      out_nxt.element  = rd_data_r;
      out_nxt.position = ptr_r[POS_W-1:0];
      out_nxt.count    = count_r;
      out_nxt.last     = dump_last;
      out_valid_nxt    = 1'b1;
    end else if (cmd.reply_load) begin
      out_nxt.status   = stat_r;
      out_nxt.element  = '0;
      out_nxt.position = '0;
      out_nxt.count    = count_r;
      out_nxt.last     = 1'b1;
      out_valid_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    stat_r <= stat_nxt;
    out_r  <= out_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/olar_ctrl.sv =====
// Controller of the ordered list: decodes a request and sequences the
// memory shift, the dump and the reply. Depends on olar_pkg.
module olar_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  olar_pkg::sts_t sts,
  output logic           in_ready,
  output olar_pkg::cmd_t cmd
);
  import olar_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        cmd.set_stat = 1'b1;
        cmd.stat     = ST_OK;
        state_nxt    = S_REPLY;
        case (sts.op)
          OP_APPEND: begin
            if (sts.is_full) begin
              cmd.stat = ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (sts.is_empty) begin
              cmd.stat = ST_EMPTY;
            end else if (sts.idx_bad) begin
              cmd.stat = ST_INVALID;
            end else if (sts.shift_none) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.ptr_idx = 1'b1;
              state_nxt   = S_SHIFT_PRIME;
            end
          end
          OP_DUMP: begin
            if (sts.is_empty) begin
              cmd.stat = ST_EMPTY;
            end else begin
              cmd.ptr_zero = 1'b1;
              state_nxt    = S_DUMP_PRIME;
            end
          end
          default: begin
            cmd.stat = ST_INVALID;
          end
        endcase
      end

      S_SHIFT_PRIME: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_NEXT;
        state_nxt  = S_SHIFT;
      end

      // Each cycle writes the element read last cycle one place forward and
      // reads the one after it, if any.
      S_SHIFT: begin
        cmd.shift_wr = 1'b1;
        if (sts.shift_done) begin
          cmd.cnt_dec  = 1'b1;
          cmd.set_stat = 1'b1;
          cmd.stat     = ST_OK;
          state_nxt    = S_REPLY;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SKIP;
        end
      end

      S_DUMP_PRIME: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PTR;
        state_nxt  = S_DUMP;
      end

      S_DUMP: begin
        if (sts.out_free) begin
          cmd.dump_load = 1'b1;
          if (sts.dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT;
          end
        end
      end

      S_REPLY: begin
        if (sts.out_free) begin
          cmd.reply_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
